@@ hw/rtl/rgb_to_ycbcr420_planar_top_assert.svh @@
// Assertion macros shared by the RGB to YCbCr 4:2:0 RTL.
`ifndef RGB_TO_YCBCR420_PLANAR_TOP_ASSERT_SVH
`define RGB_TO_YCBCR420_PLANAR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define YCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define YCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ycc_pkg.sv @@
// Shared constants, types and color math for the RGB to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps
`default_nettype none

package ycc_pkg;

  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned LUMA_ADDR_W   = 24;
  localparam int unsigned CHROMA_ADDR_W = 25;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] HALF_WIDTH_RST  = 12'd320;
  localparam logic [CFG_DATA_W-1:0] HALF_HEIGHT_RST = 12'd240;

  // BT.601 limited-range matrix
  localparam logic signed [8:0] K_Y_R  = 9'sd66;
  localparam logic signed [8:0] K_Y_G  = 9'sd129;
  localparam logic signed [8:0] K_Y_B  = 9'sd25;
  localparam logic signed [8:0] K_CB_R = -9'sd38;
  localparam logic signed [8:0] K_CB_G = -9'sd74;
  localparam logic signed [8:0] K_CB_B = 9'sd112;
  localparam logic signed [8:0] K_CR_R = 9'sd112;
  localparam logic signed [8:0] K_CR_G = -9'sd94;
  localparam logic signed [8:0] K_CR_B = -9'sd18;

  localparam logic signed [17:0] CSC_ROUND  = 18'sd128;
  localparam logic [PIX_W-1:0]   LUMA_OFS   = 8'd16;
  localparam logic [PIX_W-1:0]   CHROMA_OFS = 8'd128;

  // Position flags of one pixel, handed from the counters to the pipeline
  typedef struct packed {
    logic chroma;
    logic odd_row;
    logic last;
  } pos_flags_t;

  // Rounded dot product of one matrix row with an RGB pixel
  function automatic logic signed [17:0] csc_dot(
    input logic [PIX_W-1:0] r,
    input logic [PIX_W-1:0] g,
    input logic [PIX_W-1:0] b,
    input logic signed [8:0] kr,
    input logic signed [8:0] kg,
    input logic signed [8:0] kb
  );
    logic signed [17:0] rs;
    logic signed [17:0] gs;
    logic signed [17:0] bs;
    rs = 18'($signed({1'b0, r}));
    gs = 18'($signed({1'b0, g}));
    bs = 18'($signed({1'b0, b}));
    return rs * kr + gs * kg + bs * kb + CSC_ROUND;
  endfunction

  // Floor divide by 256, add the offset, keep eight bits
  function automatic logic [PIX_W-1:0] csc_scale(
    input logic signed [17:0] acc,
    input logic [PIX_W-1:0]   ofs
  );
    return PIX_W'(acc[15:8] + ofs);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ycc_cfg.sv @@
// Frame size registers with clamping, and the chroma plane base offsets.
`timescale 1ns / 1ps
`default_nettype none

module ycc_cfg #(
  parameter int unsigned MAX_HALF_DIMENSION = 2048
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ycc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ycc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [$clog2(MAX_HALF_DIMENSION+1)-1:0] hw_o,
  output logic [$clog2(MAX_HALF_DIMENSION+1)-1:0] hh_o,
  output logic [ycc_pkg::CHROMA_ADDR_W-1:0]   base_cr_o,
  output logic [ycc_pkg::CHROMA_ADDR_W-1:0]   base_cb_o
);
  import ycc_pkg::*;

  localparam int unsigned HD_W   = $clog2(MAX_HALF_DIMENSION + 1);
  localparam int unsigned CMP_W  = (HD_W > CFG_DATA_W) ? HD_W : CFG_DATA_W;
  localparam int unsigned WIDE_W = (2 * HD_W + 3 > CHROMA_ADDR_W) ? 2 * HD_W + 3
                                                                  : CHROMA_ADDR_W;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [HD_W-1:0] clamp_half(input logic [CFG_DATA_W-1:0] v);
    logic [CMP_W-1:0] ve;
    logic [HD_W-1:0]  res;
    ve = CMP_W'(v);
    if (ve == '0) begin
      res = HD_W'(1);
    end else if (ve > CMP_W'(MAX_HALF_DIMENSION)) begin
      res = HD_W'(MAX_HALF_DIMENSION);
    end else begin
      res = HD_W'(ve);
    end
    return res;
  endfunction

  logic [HD_W-1:0]          hw_q, hw_d;
  logic [HD_W-1:0]          hh_q, hh_d;
  logic [2*HD_W-1:0]        pairs;
  logic [WIDE_W-1:0]        quad;
  logic [WIDE_W-1:0]        quint;
  logic [CHROMA_ADDR_W-1:0] base_cr_q, base_cr_d;
  logic [CHROMA_ADDR_W-1:0] base_cb_q, base_cb_d;

  // Decode register writes
  always_comb begin
    hw_d = hw_q;
    hh_d = hh_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HALF_WIDTH:  hw_d = clamp_half(cfg_wdata_i);
        REG_HALF_HEIGHT: hh_d = clamp_half(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= clamp_half(HALF_WIDTH_RST);
      hh_q <= clamp_half(HALF_HEIGHT_RST);
    end else begin
      hw_q <= hw_d;
      hh_q <= hh_d;
    end
  end

  // Luma plane size is 4*hw*hh; Cb follows a further quarter of it
  assign pairs     = hw_q * hh_q;
  assign quad      = WIDE_W'(pairs) << 2;
  assign quint     = quad + WIDE_W'(pairs);
  assign base_cr_d = quad[CHROMA_ADDR_W-1:0];
  assign base_cb_d = quint[CHROMA_ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    base_cr_q <= base_cr_d;
    base_cb_q <= base_cb_d;
  end

  assign hw_o      = hw_q;
  assign hh_o      = hh_q;
  assign base_cr_o = base_cr_q;
  assign base_cb_o = base_cb_q;

endmodule

`default_nettype wire

@@ hw/rtl/ycc_pos.sv @@
// Column and row counters of the raster position, with frame wrap.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_ycbcr420_planar_top_assert.svh"

module ycc_pos #(
  parameter int unsigned MAX_HALF_DIMENSION = 2048
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     adv_i,
  input  wire logic [$clog2(MAX_HALF_DIMENSION+1)-1:0]  hw_i,
  input  wire logic [$clog2(MAX_HALF_DIMENSION+1)-1:0]  hh_i,
  output logic [$clog2(2*MAX_HALF_DIMENSION)-1:0]       col_o,
  output logic [$clog2(2*MAX_HALF_DIMENSION)-1:0]       row_o,
  output ycc_pkg::pos_flags_t                           flags_o
);
  import ycc_pkg::*;

  localparam int unsigned HD_W  = $clog2(MAX_HALF_DIMENSION + 1);
  localparam int unsigned CNT_W = $clog2(2 * MAX_HALF_DIMENSION);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [HD_W:0]    w_m1;
  logic [HD_W:0]    h_m1;
  logic             last_col;
  logic             last_row;

  // At or past the last column or row counts as being on it
  assign w_m1     = {hw_i, 1'b0} - (HD_W + 1)'(1);
  assign h_m1     = {hh_i, 1'b0} - (HD_W + 1)'(1);
  assign last_col = col_q >= CNT_W'(w_m1);
  assign last_row = row_q >= CNT_W'(h_m1);

  // Advance one pixel per request; wrap at line and frame end
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : CNT_W'(row_q + 1'b1);
      end else begin
        col_d = CNT_W'(col_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o           = col_q;
  assign row_o           = row_q;
  assign flags_o.chroma  = !col_q[0] && !row_q[0];
  assign flags_o.odd_row = row_q[0];
  assign flags_o.last    = last_col && last_row;

  `YCC_ASSERT_NXT(a_col_wrap, adv_i && last_col, col_q == '0, "column did not wrap")
  `YCC_ASSERT_NXT(a_col_step, adv_i && !last_col,
                  col_q == CNT_W'($past(col_q) + 1'b1), "column did not step by one")
  `YCC_ASSERT_NXT(a_pos_hold, !adv_i, $stable(col_q) && $stable(row_q), "position moved idle")

endmodule

`default_nettype wire

@@ hw/rtl/ycc_csc.sv @@
// BT.601 color matrix: luma and both color differences of one pixel.
`timescale 1ns / 1ps
`default_nettype none

module ycc_csc (
  input  wire logic [ycc_pkg::PIX_W-1:0] red_i,
  input  wire logic [ycc_pkg::PIX_W-1:0] green_i,
  input  wire logic [ycc_pkg::PIX_W-1:0] blue_i,
  output logic [ycc_pkg::PIX_W-1:0]      luma_o,
  output logic [ycc_pkg::PIX_W-1:0]      cb_o,
  output logic [ycc_pkg::PIX_W-1:0]      cr_o
);
  import ycc_pkg::*;

  logic signed [17:0] acc_y;
  logic signed [17:0] acc_cb;
  logic signed [17:0] acc_cr;

  // Constant products reduce to shift-and-add trees
  assign acc_y  = csc_dot(red_i, green_i, blue_i, K_Y_R, K_Y_G, K_Y_B);
  assign acc_cb = csc_dot(red_i, green_i, blue_i, K_CB_R, K_CB_G, K_CB_B);
  assign acc_cr = csc_dot(red_i, green_i, blue_i, K_CR_R, K_CR_G, K_CR_B);

  // Arithmetic shift, then offset
  assign luma_o = csc_scale(acc_y, LUMA_OFS);
  assign cb_o   = csc_scale(acc_cb, CHROMA_OFS);
  assign cr_o   = csc_scale(acc_cr, CHROMA_OFS);

endmodule

`default_nettype wire

@@ hw/rtl/rgb_to_ycbcr420_planar_top.sv @@
// Top level: RGB pixel stream in, planar YCbCr 4:2:0 samples and addresses out.
//
//   Port group   Direction  Handshake                 Payload
//   -----------  ---------  ------------------------  --------------------------------------
//   pixel in     in         in_valid_i / in_ready_o   red_i, green_i, blue_i
//   sample out   out        out_valid_o / out_ready_i luma_o, addresses, chroma, last
//   config       in         cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// One pixel per clock unless the output stalls; requests pass input then result register.
// The pixel counters advance on the input request; the color matrix and the
// address multiply (row pair times half width) sit between the input and result
// registers. Reset clears counters, valid flags and restores 320 x 240 pairs.
// A stalled output holds its result while the input register still takes one more.
// Chroma base offsets follow a write via the size registers, then their own register.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_ycbcr420_planar_top_assert.svh"

module rgb_to_ycbcr420_planar_top #(
  parameter int unsigned MAX_HALF_DIMENSION = 2048
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [ycc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ycc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Pixel input
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [ycc_pkg::PIX_W-1:0]      red_i,
  input  wire logic [ycc_pkg::PIX_W-1:0]      green_i,
  input  wire logic [ycc_pkg::PIX_W-1:0]      blue_i,
  // Sample output
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ycc_pkg::PIX_W-1:0]           luma_o,
  output logic [ycc_pkg::LUMA_ADDR_W-1:0]     luma_address_o,
  output logic                                chroma_valid_o,
  output logic [ycc_pkg::PIX_W-1:0]           blue_difference_o,
  output logic [ycc_pkg::PIX_W-1:0]           red_difference_o,
  output logic [ycc_pkg::CHROMA_ADDR_W-1:0]   red_difference_address_o,
  output logic [ycc_pkg::CHROMA_ADDR_W-1:0]   blue_difference_address_o,
  output logic                                frame_last_o
);
  import ycc_pkg::*;

  localparam int unsigned HD_W   = $clog2(MAX_HALF_DIMENSION + 1);
  localparam int unsigned CNT_W  = $clog2(2 * MAX_HALF_DIMENSION);
  localparam int unsigned RH_W   = (CNT_W > 1) ? CNT_W - 1 : 1;
  localparam int unsigned PROD_W = RH_W + HD_W;
  localparam int unsigned ASUM_W = (PROD_W + 3 > CHROMA_ADDR_W) ? PROD_W + 3 : CHROMA_ADDR_W;

  logic [HD_W-1:0]          hw;
  logic [HD_W-1:0]          hh;
  logic [CHROMA_ADDR_W-1:0] base_cr;
  logic [CHROMA_ADDR_W-1:0] base_cb;
  logic [CNT_W-1:0]         pos_col;
  logic [CNT_W-1:0]         pos_row;
  pos_flags_t               pos_flags;

  logic in_acc;
  logic out_load;

  // Input register
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_red_q, s1_green_q, s1_blue_q;
  logic [CNT_W-1:0] s1_col_q;
  logic [CNT_W-1:0] s1_row_q;
  pos_flags_t       s1_flags_q;

  // Result register
  logic                     out_valid_q, out_valid_d;
  logic [PIX_W-1:0]         luma_q, luma_d;
  logic [LUMA_ADDR_W-1:0]   luma_addr_q, luma_addr_d;
  logic                     chroma_q, chroma_d;
  logic [PIX_W-1:0]         cb_q, cb_d;
  logic [PIX_W-1:0]         cr_q, cr_d;
  logic [CHROMA_ADDR_W-1:0] cr_addr_q, cr_addr_d;
  logic [CHROMA_ADDR_W-1:0] cb_addr_q, cb_addr_d;
  logic                     last_q, last_d;

  // Datapath between the two registers
  logic [PIX_W-1:0]         csc_luma;
  logic [PIX_W-1:0]         csc_cb;
  logic [PIX_W-1:0]         csc_cr;
  logic [RH_W-1:0]          row_pair;
  logic [PROD_W-1:0]        pair_off;
  logic [ASUM_W-1:0]        luma_sum;
  logic [ASUM_W-1:0]        chroma_idx;
  logic [CHROMA_ADDR_W-1:0] cr_sum;
  logic [CHROMA_ADDR_W-1:0] cb_sum;

  ycc_cfg #(
    .MAX_HALF_DIMENSION(MAX_HALF_DIMENSION)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .hw_o       (hw),
    .hh_o       (hh),
    .base_cr_o  (base_cr),
    .base_cb_o  (base_cb)
  );

  ycc_pos #(
    .MAX_HALF_DIMENSION(MAX_HALF_DIMENSION)
  ) u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_acc),
    .hw_i   (hw),
    .hh_i   (hh),
    .col_o  (pos_col),
    .row_o  (pos_row),
    .flags_o(pos_flags)
  );

  ycc_csc u_csc (
    .red_i  (s1_red_q),
    .green_i(s1_green_q),
    .blue_i (s1_blue_q),
    .luma_o (csc_luma),
    .cb_o   (csc_cb),
    .cr_o   (csc_cr)
  );

  // Handshake: the result register frees the input register when it can load
  assign out_load    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || out_load;
  assign in_acc      = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the pixel with its position
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_red_q   <= red_i;
      s1_green_q <= green_i;
      s1_blue_q  <= blue_i;
      s1_col_q   <= pos_col;
      s1_row_q   <= pos_row;
      s1_flags_q <= pos_flags;
    end
  end

  // Row pair times half width gives both the luma line and the chroma line offset
  assign row_pair   = RH_W'(s1_row_q >> 1);
  assign pair_off   = row_pair * hw;
  assign luma_sum   = (ASUM_W'(pair_off) << 2)
                    + (s1_flags_q.odd_row ? ASUM_W'({hw, 1'b0}) : '0)
                    + ASUM_W'(s1_col_q);
  assign chroma_idx = ASUM_W'(pair_off) + ASUM_W'(s1_col_q >> 1);
  assign cr_sum     = base_cr + chroma_idx[CHROMA_ADDR_W-1:0];
  assign cb_sum     = base_cb + chroma_idx[CHROMA_ADDR_W-1:0];

  // Zero the chroma fields off the even-even grid
  assign luma_d      = csc_luma;
  assign luma_addr_d = luma_sum[LUMA_ADDR_W-1:0];
  assign chroma_d    = s1_flags_q.chroma;
  assign cb_d        = s1_flags_q.chroma ? csc_cb : '0;
  assign cr_d        = s1_flags_q.chroma ? csc_cr : '0;
  assign cr_addr_d   = s1_flags_q.chroma ? cr_sum : '0;
  assign cb_addr_d   = s1_flags_q.chroma ? cb_sum : '0;
  assign last_d      = s1_flags_q.last;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      luma_q      <= luma_d;
      luma_addr_q <= luma_addr_d;
      chroma_q    <= chroma_d;
      cb_q        <= cb_d;
      cr_q        <= cr_d;
      cr_addr_q   <= cr_addr_d;
      cb_addr_q   <= cb_addr_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o               = out_valid_q;
  assign luma_o                    = luma_q;
  assign luma_address_o            = luma_addr_q;
  assign chroma_valid_o            = chroma_q;
  assign blue_difference_o         = cb_q;
  assign red_difference_o          = cr_q;
  assign red_difference_address_o  = cr_addr_q;
  assign blue_difference_address_o = cb_addr_q;
  assign frame_last_o              = last_q;

  `YCC_ASSERT_IMP(a_chroma_zero, out_valid_o && !chroma_valid_o,
                  blue_difference_o == '0 && red_difference_o == '0 &&
                  red_difference_address_o == '0 && blue_difference_address_o == '0,
                  "chroma fields nonzero off grid")
  `YCC_ASSERT_NXT(a_stage_fill, in_valid_i && in_ready_o, s1_valid_q,
                  "accepted request not held in input register")
  `YCC_ASSERT_IMP(a_full_stall, s1_valid_q && out_valid_o && !out_ready_i, !in_ready_o,
                  "ready while both registers full and stalled")

endmodule

`default_nettype wire
